@@ rtl/core/rmth_pkg.sv @@
// Package: sizes and types for the two-heap running median block.
package rmth_pkg;
   localparam int CAPACITY    = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int LOWER_DEPTH = (CAPACITY + 1) / 2;
   localparam int UPPER_DEPTH = CAPACITY / 2;
   localparam int ADDR_BITS   = $clog2(LOWER_DEPTH);
   localparam int HCNT_BITS   = $clog2(LOWER_DEPTH + 1);
   localparam int COUNT_BITS  = 11;
   localparam int MED_BITS    = SAMPLE_BITS + 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic signed [MED_BITS-1:0] median_twice;
      logic [COUNT_BITS-1:0]      sample_count;
      logic                       dropped;
   } rsp_type;
endpackage

@@ rtl/core/rmth_if.sv @@
// Interfaces: request and response channels of the running median block.
interface rmth_req_if;
   logic                valid;
   logic                ready;
   rmth_pkg::sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface rmth_rsp_if;
   logic             valid;
   logic             ready;
   rmth_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/running_median_two_heap.sv @@
// Top level: running median over all samples kept in a max-heap and a min-heap.
// Memory: one memory access per cycle on a shared heap port; an insert sifts
//   down one heap if its top moves, then pushes onto the other heap and sifts up.
// Throughput: one item at a time; ready is low while the heap sequencer runs.
// A dropped sample skips the heap updates. The result register frees the sequencer.
// Reset (synchronous, active high) clears both counts; heap contents stay.
module running_median_two_heap (
   input  logic             clock,
   input  logic             reset,
   rmth_req_if.sink         req,
   rmth_rsp_if.source       rsp
);
   localparam int AB = rmth_pkg::ADDR_BITS;
   localparam int CB = rmth_pkg::HCNT_BITS;
   localparam int SB = rmth_pkg::SAMPLE_BITS;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_TOPS   = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_DN_L   = 4'd3;
   localparam logic [3:0] S_DN_R   = 4'd4;
   localparam logic [3:0] S_DN_CMP = 4'd5;
   localparam logic [3:0] S_PUSH   = 4'd6;
   localparam logic [3:0] S_UP_RD  = 4'd7;
   localparam logic [3:0] S_UP_CMP = 4'd8;
   localparam logic [3:0] S_FIN    = 4'd9;
   localparam logic [3:0] S_FIN2   = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   // heap memories: index 0 is the lower (max) heap, 1 the upper (min) heap
   logic [SB-1:0] mem_lo [rmth_pkg::LOWER_DEPTH];
   logic [SB-1:0] mem_hi [rmth_pkg::LOWER_DEPTH];

   logic [3:0]   state_ff, state_in;
   logic [CB-1:0] lcnt_ff, lcnt_in, ucnt_ff, ucnt_in;
   logic signed [SB-1:0] x_ff, x_in;      // value being placed
   logic signed [SB-1:0] t_ff, t_in;      // displaced top for push
   logic signed [SB-1:0] lc_ff, lc_in;    // left child value
   logic signed [SB-1:0] top_lo_ff, top_hi_ff;
   logic signed [SB-1:0] rd_ff;
   logic [AB:0]  i_ff, i_in;              // one extra bit for child addresses
   logic         heap_ff, heap_in;        // heap being worked on
   logic         push_ff, push_in;        // pending push after sift-down
   logic         drop_ff, drop_in;
   logic         rvalid_ff;
   rmth_pkg::rsp_type rdata_ff;

   // single memory port control
   logic         we, re, rsel;
   logic [AB-1:0] addr;
   logic [SB-1:0] wdata;

   logic [CB:0]   total;
   logic [AB+1:0] lch, rch;
   logic [CB-1:0] hcnt;
   logic          rank;   // ca outranks cb_v: shared comparator
   logic signed [SB-1:0] ca, cb_v;
   logic          out_go; // result register can take a new item

   assign total = {1'b0, lcnt_ff} + {1'b0, ucnt_ff};
   assign lch   = {i_ff, 1'b1};
   assign rch   = {i_ff, 1'b0} + (AB+2)'(2);
   assign hcnt  = heap_ff ? ucnt_ff : lcnt_ff;
   assign out_go = !rvalid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rvalid_ff;
   assign rsp.data  = rdata_ff;

   // shared comparator: true when ca must sit above cb_v in the current heap; in S_DECIDE, x needs no top swap
   always_comb begin
      ca   = rd_ff;
      cb_v = x_ff;
      unique case (state_ff)
         S_DECIDE: begin
            ca = x_ff;
            cb_v = (lcnt_ff == ucnt_ff) ? top_hi_ff : top_lo_ff;
         end
         S_DN_CMP: begin
            ca = rd_ff;
            cb_v = lc_ff;
         end
         default: begin
            ca = rd_ff;
            cb_v = x_ff;
         end
      endcase
      if (state_ff == S_DECIDE) rank = (lcnt_ff == ucnt_ff) ? (ca < cb_v) : (ca >= cb_v);
      else rank = heap_ff ? (ca < cb_v) : (ca > cb_v);
   end

   // memory access
   always_ff @(posedge clock) begin
      if (we) begin
         if (rsel) mem_hi[addr] <= wdata;
         else      mem_lo[addr] <= wdata;
      end
      if (re) rd_ff <= rsel ? mem_hi[addr] : mem_lo[addr];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      lcnt_in = lcnt_ff; ucnt_in = ucnt_ff;
      x_in = x_ff; t_in = t_ff; lc_in = lc_ff; i_in = i_ff;
      heap_in = heap_ff; push_in = push_ff; drop_in = drop_ff;
      we = 1'b0; re = 1'b0; rsel = heap_ff; addr = i_ff[AB-1:0]; wdata = x_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               x_in = req.sample;
               drop_in = (total >= (CB+1)'(rmth_pkg::CAPACITY));
               state_in = (total >= (CB+1)'(rmth_pkg::CAPACITY)) ? S_FIN : S_TOPS;
            end
         end
         S_TOPS: state_in = S_DECIDE; // tops registers already valid
         S_DECIDE: begin
            if (lcnt_ff == '0) begin
               heap_in = 1'b0; t_in = x_ff; state_in = S_PUSH;
            end else if (lcnt_ff == ucnt_ff) begin
               if (rank) begin
                  heap_in = 1'b0; t_in = x_ff; state_in = S_PUSH;
               end else begin
                  heap_in = 1'b1; t_in = top_hi_ff; push_in = 1'b1;
                  i_in = '0; state_in = S_DN_L;
               end
            end else begin
               if (rank) begin
                  heap_in = 1'b1; t_in = x_ff; state_in = S_PUSH;
               end else begin
                  heap_in = 1'b0; t_in = top_lo_ff; push_in = 1'b1;
                  i_in = '0; state_in = S_DN_L;
               end
            end
         end
         // sift-down: read left child, then right child, compare in turn
         S_DN_L: begin
            if (lch >= (AB+2)'(hcnt)) begin
               we = 1'b1; state_in = S_FIN;
            end else begin
               re = 1'b1; addr = lch[AB-1:0]; state_in = S_DN_R;
            end
         end
         S_DN_R: begin
            lc_in = rd_ff;
            if (rch < (AB+2)'(hcnt)) begin
               re = 1'b1; addr = rch[AB-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            // rd_ff holds right child if present; pick best child in lc_ff
            if (rch < (AB+2)'(hcnt) && rank) begin
               lc_in = rd_ff; i_in = i_ff; push_in = push_ff;
               if (heap_ff ? (rd_ff < x_ff) : (rd_ff > x_ff)) begin
                  we = 1'b1; wdata = rd_ff; i_in = rch[AB:0];
                  state_in = S_DN_L;
               end else begin
                  we = 1'b1; state_in = S_FIN;
               end
            end else if (heap_ff ? (lc_ff < x_ff) : (lc_ff > x_ff)) begin
               we = 1'b1; wdata = lc_ff; i_in = lch[AB:0]; state_in = S_DN_L;
            end else begin
               we = 1'b1; state_in = S_FIN;
            end
         end
         // push t onto the other heap: append, then sift up
         S_PUSH: begin
            x_in = t_ff;
            i_in = {1'b0, hcnt[AB-1:0]};
            if (heap_ff) ucnt_in = ucnt_ff + 1'b1;
            else         lcnt_in = lcnt_ff + 1'b1;
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            if (i_ff == '0) begin
               we = 1'b1; state_in = S_FIN;
            end else begin
               re = 1'b1; addr = AB'((i_ff - 1'b1) >> 1); state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (heap_ff ? (x_ff < rd_ff) : (x_ff > rd_ff)) begin
               we = 1'b1; wdata = rd_ff;
               i_in = (i_ff - 1'b1) >> 1;
               state_in = S_UP_RD;
            end else begin
               we = 1'b1; state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (push_ff) begin
               push_in = 1'b0; heap_in = !heap_ff; state_in = S_PUSH;
            end else begin
               re = 1'b1; rsel = 1'b0; addr = '0; state_in = S_FIN2;
            end
         end
         S_FIN2: begin
            re = 1'b1; rsel = 1'b1; addr = '0; state_in = S_OUT;
         end
         // hold until the result register is free
         S_OUT: state_in = out_go ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   // registers, tops refresh and result
   always_ff @(posedge clock) begin
      x_ff <= x_in; t_ff <= t_in; lc_ff <= lc_in; i_ff <= i_in;
      heap_ff <= heap_in; drop_ff <= drop_in;
      if (state_ff == S_FIN2) top_lo_ff <= rd_ff;
      if (state_ff == S_OUT)  top_hi_ff <= rd_ff;
      if (reset) begin
         state_ff <= S_IDLE; lcnt_ff <= '0; ucnt_ff <= '0;
         push_ff <= 1'b0; rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; lcnt_ff <= lcnt_in; ucnt_ff <= ucnt_in;
         push_ff <= push_in;
         if (state_ff == S_OUT && out_go) begin
            rvalid_ff <= 1'b1;
            rdata_ff.dropped <= drop_ff;
            rdata_ff.sample_count <= rmth_pkg::COUNT_BITS'(total);
            if (lcnt_ff > ucnt_ff)
               rdata_ff.median_twice <= {top_lo_ff, 1'b0};
            else if (lcnt_ff != '0)
               rdata_ff.median_twice <= {top_lo_ff[SB-1], top_lo_ff} + {rd_ff[SB-1], rd_ff};
            else
               rdata_ff.median_twice <= '0;
         end else if (rsp.ready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end
endmodule

@@ bench/running_median_two_heap_tb.sv @@
// Testbench for the two-heap running median block: random samples, self-checking.
`timescale 1ns / 1ps
module running_median_two_heap_tb;

   logic clock;
   logic reset;

   rmth_req_if req_ch ();
   rmth_rsp_if rsp_ch ();

   running_median_two_heap dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // predictor state: sorted copy of every stored sample
   int                    kept_samples[$];
   rmth_pkg::rsp_type     median_due[$];
   rmth_pkg::sample_type  sample_queue[$];
   int          fail_count;
   int          quiet_cycles;
   bit          calm_driver;
   bit          calm_monitor;

   localparam int WATCHDOG_LIMIT = 20000;

   // insert one sample into the kept set and compute the expected result
   function automatic rmth_pkg::rsp_type predict_median(rmth_pkg::sample_type smp);
      rmth_pkg::rsp_type r;
      int      pos;
      int      n;
      int      lo_top;
      if (kept_samples.size() >= rmth_pkg::CAPACITY) begin
         r.dropped = 1'b1;
      end else begin
         r.dropped = 1'b0;
         pos = 0;
         while (pos < kept_samples.size() && kept_samples[pos] <= int'(smp)) pos++;
         kept_samples.insert(pos, int'(smp));
      end
      n = kept_samples.size();
      lo_top = kept_samples[(n - 1) / 2];
      if (n % 2 == 1) r.median_twice = rmth_pkg::MED_BITS'(2 * lo_top);
      else            r.median_twice = rmth_pkg::MED_BITS'(lo_top + kept_samples[n / 2]);
      r.sample_count = rmth_pkg::COUNT_BITS'(n);
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // driver: advance through the queue of pending items
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid  <= 1'b0;
         req_ch.sample <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) median_due.push_back(predict_median(req_ch.sample));
         if (sample_queue.size() > 0 && (calm_driver || $urandom_range(99) >= 33)) begin
            req_ch.valid  <= 1'b1;
            req_ch.sample <= sample_queue.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: stall at random, check each accepted result
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (median_due.size() == 0) begin
               $error("result with nothing expected: %p", rsp_ch.data);
               fail_count++;
            end else begin
               rmth_pkg::rsp_type e;
               e = median_due.pop_front();
               if (rsp_ch.data.median_twice !== e.median_twice) begin
                  $error("median_twice exp %0d got %0d", e.median_twice,
                         rsp_ch.data.median_twice);
                  fail_count++;
               end
               if (rsp_ch.data.sample_count !== e.sample_count) begin
                  $error("sample_count exp %0d got %0d", e.sample_count,
                         rsp_ch.data.sample_count);
                  fail_count++;
               end
               if (rsp_ch.data.dropped !== e.dropped) begin
                  $error("dropped exp %0b got %0b", e.dropped, rsp_ch.data.dropped);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= calm_monitor || ($urandom_range(99) >= 33);
      end
   end

   // watchdog: count cycles with no item accepted on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      rmth_pkg::sample_type s;
      int k;
      int phase;
      fail_count   = 0;
      calm_driver  = 1'b0;
      calm_monitor = 1'b0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, ties, alternating sides
      sample_queue.push_back(16'sh0000);
      sample_queue.push_back(16'sh7FFF);
      sample_queue.push_back(16'sh8000);
      sample_queue.push_back(16'sh8000);
      sample_queue.push_back(16'sh7FFF);
      sample_queue.push_back(16'sh7FFF);
      sample_queue.push_back(16'sh0000);
      sample_queue.push_back(16'sh0000);
      sample_queue.push_back(16'shFFFF);
      sample_queue.push_back(16'sh0001);
      sample_queue.push_back(16'sh5555);
      sample_queue.push_back(16'shAAAA);
      for (k = 0; k < 8; k++)
         sample_queue.push_back(rmth_pkg::sample_type'(k % 2 ? -k : k));

      // random: mixed ranges
      for (k = 0; k < 830; k++) begin
         phase = $urandom_range(9);
         if (phase < 2)      s = rmth_pkg::sample_type'($urandom_range(8) - 4);
         else if (phase < 3) s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         else                s = rmth_pkg::sample_type'($urandom);
         sample_queue.push_back(s);
         // a stretch with no idling on either side
         if (k == 400) begin
            while (sample_queue.size() > 0) @(posedge clock);
            calm_driver  <= 1'b1;
            calm_monitor <= 1'b1;
         end
         if (k == 600) begin
            while (sample_queue.size() > 0) @(posedge clock);
            calm_driver  <= 1'b0;
            calm_monitor <= 1'b0;
         end
      end
      while (sample_queue.size() > 0 || req_ch.valid) @(posedge clock);
      while (median_due.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
